// ===== src/orb_pkg.sv =====
// Shared types, constants and position arithmetic for the overwriting ring buffer.
package orb_pkg;

   localparam int MAX_DEPTH = 16;
   localparam int POS_W     = $clog2(MAX_DEPTH);
   localparam int CAP_W     = 5;
   localparam int WORD_W    = 32;
   localparam int CNT_W     = POS_W + 1;

   localparam logic [1:0] ACT_PUT  = 2'd0;
   localparam logic [1:0] ACT_GET  = 2'd1;
   localparam logic [1:0] ACT_DUMP = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUT_WR,
      ST_PUT_RD,
      ST_GET,
      ST_GET_OUT,
      ST_DUMP_CNT,
      ST_DUMP_RD,
      ST_DUMP_OUT,
      ST_NONE
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [POS_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [POS_W-1:0]  rd_addr;
   } store_req_type;

   function automatic logic [CAP_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] c;
      c = cap;
      if (c == '0) c = CAP_W'(1);
      if (c > CAP_W'(MAX_DEPTH)) c = CAP_W'(MAX_DEPTH);
      return c;
   endfunction

   function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos,
                                                input logic [CAP_W-1:0] eff);
      logic [CAP_W-1:0] n;
      n = CAP_W'(pos) + CAP_W'(1);
      if (n >= eff) n = '0;
      return n[POS_W-1:0];
   endfunction

endpackage

// ===== src/orb_store.sv =====
// Word store of the ring buffer: one write port and one registered read port.
module orb_store
   import orb_pkg::*;
(
   input  logic              clock,
   input  store_req_type     store_req,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [MAX_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/overwriting_ring_buffer_top.sv =====
// Top level of the overwriting ring buffer: sequencer, positions, flags and result register.
//
//   channel  direction  tdata          tuser                               tlast
//   req      in         put_value      action                              -
//   rsp      out        word_out       word_valid, now_empty, now_full     last_of_run
//   csr      in         buffer_capacity (write only, csr_wr_en/csr_wr_data)
//
// A put runs ST_PUT_WR, ST_PUT_RD; a get ST_GET, ST_GET_OUT; an empty get or unused action
// ends in ST_NONE. A dump runs ST_DUMP_CNT, then ST_DUMP_RD and ST_DUMP_OUT per held word,
// or ST_NONE if none is held. The states share one advance unit; store reads are registered.
// Reset is synchronous and clears the positions and flags; the store keeps its contents.
// A stalled result holds the sequencer at the next result it wants to show.
module overwriting_ring_buffer_top
   import orb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic signed [WORD_W-1:0] req_tdata,  // put_value
   input  logic [1:0]               req_tuser,  // action
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic signed [WORD_W-1:0] rsp_tdata,  // word_out
   output logic [2:0]               rsp_tuser,  // word_valid, now_empty, now_full
   output logic                     rsp_tlast,  // last_of_run
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data
);

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  wp_ff, wp_in;
   logic [POS_W-1:0]  rp_ff, rp_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              empty_ff, empty_in;
   logic              full_ff, full_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [WORD_W-1:0] val_ff, val_in;

   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_valid_ff, rsp_wvalid_ff, rsp_empty_ff, rsp_full_ff, rsp_last_ff;

   logic              emit;
   logic [WORD_W-1:0] emit_word;
   logic              emit_wvalid, emit_empty, emit_full, emit_last;

   logic              out_free;
   logic [CAP_W-1:0]  eff;
   logic [POS_W-1:0]  adv_arg, adv_res;
   logic signed [CNT_W:0] dump_count;
   logic              dump_some;
   logic [WORD_W-1:0] rd_data;
   store_req_type     store_req;

   orb_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   assign eff      = eff_capacity(cap_ff);
   assign adv_res  = advance(adv_arg, eff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign dump_count = (wp_ff > rp_ff)
                     ? ((CNT_W+1)'(wp_ff) - (CNT_W+1)'(rp_ff))
                     : ((CNT_W+1)'(eff) - ((CNT_W+1)'(rp_ff) - (CNT_W+1)'(wp_ff)));
   assign dump_some  = !empty_ff && !dump_count[CNT_W] && (dump_count != '0);

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      empty_in    = empty_ff;
      full_in     = full_ff;
      val_in      = val_ff;
      adv_arg     = wp_ff;
      emit        = 1'b0;
      emit_word   = '1;
      emit_wvalid = 1'b0;
      emit_empty  = empty_ff;
      emit_full   = full_ff;
      emit_last   = 1'b1;
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = wp_ff;
      store_req.wr_data = val_ff;
      store_req.rd_en   = 1'b0;
      store_req.rd_addr = rp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               val_in = req_tdata;
               case (req_tuser)
                  ACT_PUT:  state_in = ST_PUT_WR;
                  ACT_GET:  state_in = ST_GET;
                  ACT_DUMP: state_in = ST_DUMP_CNT;
                  default:  state_in = ST_NONE;
               endcase
            end
         end
         ST_PUT_WR: begin
            store_req.wr_en = 1'b1;
            adv_arg         = wp_ff;
            wp_in           = adv_res;
            empty_in        = 1'b0;
            state_in        = ST_PUT_RD;
         end
         ST_PUT_RD: begin
            adv_arg = rp_ff;
            if (out_free) begin
               emit       = 1'b1;
               emit_empty = 1'b0;
               emit_full  = full_ff || (wp_ff == rp_ff);
               if (full_ff) begin
                  rp_in = adv_res;
               end else begin
                  full_in = (wp_ff == rp_ff);
               end
               state_in = ST_IDLE;
            end
         end
         ST_GET: begin
            full_in = 1'b0;
            adv_arg = rp_ff;
            if (empty_ff) begin
               state_in = ST_NONE;
            end else begin
               store_req.rd_en = 1'b1;
               rp_in           = adv_res;
               state_in        = ST_GET_OUT;
            end
         end
         ST_GET_OUT: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_word   = rd_data;
               emit_wvalid = 1'b1;
               emit_empty  = (rp_ff == wp_ff);
               emit_full   = 1'b0;
               empty_in    = (rp_ff == wp_ff);
               state_in    = ST_IDLE;
            end
         end
         ST_DUMP_CNT: begin
            if (dump_some) begin
               cnt_in   = dump_count[CNT_W-1:0];
               pos_in   = rp_ff;
               state_in = ST_DUMP_RD;
            end else begin
               state_in = ST_NONE;
            end
         end
         ST_DUMP_RD: begin
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = pos_ff;
            adv_arg           = pos_ff;
            pos_in            = adv_res;
            cnt_in            = cnt_ff - CNT_W'(1);
            state_in          = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_word   = rd_data;
               emit_wvalid = 1'b1;
               emit_last   = (cnt_ff == '0);
               state_in    = (cnt_ff == '0) ? ST_IDLE : ST_DUMP_RD;
            end
         end
         ST_NONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
         empty_ff <= 1'b1;
         full_ff  <= 1'b0;
         cap_ff   <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         empty_ff <= empty_in;
         full_ff  <= full_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      if (emit) begin
         rsp_word_ff   <= emit_word;
         rsp_wvalid_ff <= emit_wvalid;
         rsp_empty_ff  <= emit_empty;
         rsp_full_ff   <= emit_full;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = {rsp_full_ff, rsp_empty_ff, rsp_wvalid_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The buffer can never be empty and full at once.
   assert property (@(posedge clock) disable iff (reset) !(empty_ff && full_ff))
      else $error("empty and full flags set together");

   // Only one item is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while busy");

   // A dump word that is not the last one comes from a buffer that holds words.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] && !rsp_tlast) |-> !rsp_tuser[1])
      else $error("dump word reported with empty buffer");

   // A result never reports the buffer as full and empty together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && rsp_tuser[2]))
      else $error("result reports empty and full");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the overwriting ring buffer top level.
`timescale 1ns / 100ps

module tb_top;
   import orb_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int IDLE_SETTLE = 8;
   localparam int END_SETTLE  = 40;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              valid;
      logic              empty;
      logic              full;
      logic              last;
   } ring_result_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic signed [WORD_W-1:0] req_tdata;   // put_value
   logic [1:0]               req_tuser;   // action
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic signed [WORD_W-1:0] rsp_tdata;   // word_out
   logic [2:0]               rsp_tuser;   // word_valid, now_empty, now_full
   logic                     rsp_tlast;   // last_of_run
   logic                     csr_wr_en;
   logic [CAP_W-1:0]         csr_wr_data;

   ring_result_type   pending_results[$];
   ring_result_type   front_result;
   int                error_count = 0;

   logic [WORD_W-1:0] ring_mem [MAX_DEPTH];
   logic [POS_W-1:0]  wr_pos;
   logic [POS_W-1:0]  rd_pos;
   logic              is_empty;
   logic              is_full;
   logic [CAP_W-1:0]  cap_reg;

   int                burst_left = 1;
   bit                steady_stretch = 1'b0;
   int                stall_count = 0;
   int                stall_mode = 0;

   overwriting_ring_buffer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int ring_eff_cap();
      int c;
      c = cap_reg;
      if (c < 1) c = 1;
      if (c > MAX_DEPTH) c = MAX_DEPTH;
      return c;
   endfunction

   function automatic logic [POS_W-1:0] ring_next_pos(input logic [POS_W-1:0] p);
      int n;
      n = int'(p) + 1;
      if (n >= ring_eff_cap()) n = 0;
      return POS_W'(n);
   endfunction

   function automatic void push_result(input logic [WORD_W-1:0] word, input logic valid,
                                       input logic last);
      ring_result_type r;
      r.word  = word;
      r.valid = valid;
      r.empty = is_empty;
      r.full  = is_full;
      r.last  = last;
      pending_results.push_back(r);
   endfunction

   function automatic void predict_ring(input logic [1:0] act, input logic [WORD_W-1:0] val);
      int               count;
      logic [POS_W-1:0] pos;
      count = 0;
      case (act)
         ACT_PUT: begin
            is_empty = 1'b0;
            ring_mem[wr_pos] = val;
            wr_pos = ring_next_pos(wr_pos);
            if (is_full) rd_pos = ring_next_pos(rd_pos);
            else if (wr_pos == rd_pos) is_full = 1'b1;
            push_result('1, 1'b0, 1'b1);
         end
         ACT_GET: begin
            is_full = 1'b0;
            if (!is_empty) begin
               pos = rd_pos;
               rd_pos = ring_next_pos(rd_pos);
               if (rd_pos == wr_pos) is_empty = 1'b1;
               push_result(ring_mem[pos], 1'b1, 1'b1);
            end else begin
               push_result('1, 1'b0, 1'b1);
            end
         end
         ACT_DUMP: begin
            if (!is_empty) begin
               if (wr_pos > rd_pos) count = int'(wr_pos) - int'(rd_pos);
               else count = ring_eff_cap() - (int'(rd_pos) - int'(wr_pos));
            end
            if (count > MAX_DEPTH) count = MAX_DEPTH;
            if (count <= 0) begin
               push_result('1, 1'b0, 1'b1);
            end else begin
               pos = rd_pos;
               for (int k = 0; k < count; k++) begin
                  push_result(ring_mem[pos], 1'b1, k + 1 == count);
                  pos = ring_next_pos(pos);
               end
            end
         end
         default: begin
            push_result('1, 1'b0, 1'b1);
         end
      endcase
   endfunction

   task automatic hold_idle(input int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_item(input logic [1:0] act, input logic [WORD_W-1:0] val);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= val;
      do @(posedge clock); while (!req_tready);
      predict_ring(act, val);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         hold_idle(steady_stretch ? 0 : $urandom_range(1, 6));
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] c);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      cap_reg = c;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_buffer();
      send_item(ACT_GET, 32'h0000_0000);
      send_item(ACT_DUMP, 32'hFFFF_FFFF);
      send_item(ACT_UNUSED, 32'h5555_5555);
   endtask

   task automatic test_fill_and_overwrite();
      logic [WORD_W-1:0] edge_words[6];
      edge_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'h5555_5555, 32'hAAAA_AAAA};
      for (int i = 0; i < MAX_DEPTH; i++)
         send_item(ACT_PUT, i < 6 ? edge_words[i] : $urandom);
      send_item(ACT_DUMP, $urandom);
      send_item(ACT_PUT, 32'h1234_5678);
      send_item(ACT_DUMP, $urandom);
      send_item(ACT_GET, $urandom);
      send_item(ACT_DUMP, $urandom);
   endtask

   task automatic run_random_items(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) send_item(ACT_PUT, pick_word());
         else if (pick < 75) send_item(ACT_GET, $urandom);
         else if (pick < 93) send_item(ACT_DUMP, $urandom);
         else send_item(ACT_UNUSED, $urandom);
         if ($urandom_range(0, 19) == 0) wait_drained();
      end
   endtask

   task automatic test_capacity_sweep();
      logic [CAP_W-1:0] caps[8];
      caps = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16, 5'd0, 5'd0};
      caps[6] = CAP_W'($urandom_range(2, 15));
      caps[7] = CAP_W'($urandom);
      foreach (caps[i]) begin
         wait_drained();
         write_capacity(caps[i]);
         steady_stretch = ($urandom_range(0, 3) == 0);
         run_random_items(11);
      end
      steady_stretch = 1'b0;
   endtask

   always @(posedge clock) begin
      stall_count++;
      if (stall_count % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= (stall_count % 5 == 0);
         default: rsp_tready <= (stall_count % 8 < 5);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected item: word_out %h", rsp_tdata);
            error_count++;
         end else begin
            front_result = pending_results.pop_front();
            if (rsp_tdata !== front_result.word) begin
               $error("word_out: expected %h, got %h", front_result.word, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== front_result.valid) begin
               $error("word_valid: expected %b, got %b", front_result.valid, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tuser[1] !== front_result.empty) begin
               $error("now_empty: expected %b, got %b", front_result.empty, rsp_tuser[1]);
               error_count++;
            end
            if (rsp_tuser[2] !== front_result.full) begin
               $error("now_full: expected %b, got %b", front_result.full, rsp_tuser[2]);
               error_count++;
            end
            if (rsp_tlast !== front_result.last) begin
               $error("last_of_run: expected %b, got %b", front_result.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("overwriting_ring_buffer_top: mismatch");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = ACT_PUT;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      wr_pos      = '0;
      rd_pos      = '0;
      is_empty    = 1'b1;
      is_full     = 1'b0;
      cap_reg     = CAP_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_buffer();
      test_fill_and_overwrite();
      test_capacity_sweep();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("overwriting_ring_buffer_top: match");
      end else begin
         $display("overwriting_ring_buffer_top: mismatch");
      end
      $finish;
   end

endmodule
